FILE: design/cmf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the credit counted message fifo
// no dependencies

package cmf_pkg;

  localparam int ID_W         = 32;
  localparam int SIZE_W       = 16;
  localparam int CMD_W        = 2;
  localparam int FLIT_W       = 11;
  localparam int COST_W       = 16;
  localparam int CREDIT_OUT_W = 5;
  localparam int OPQ_DEPTH    = 2;
  localparam int DIV_STEPS    = 4;

  localparam logic [FLIT_W-1:0] FLIT_RESET = 11'd64;

  localparam logic [CMD_W-1:0] CMD_IDLE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_PUSH = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   msg_id;
    logic [SIZE_W-1:0] msg_size;
  } item_t;

  typedef struct packed {
    logic                    head_valid;
    logic [ID_W-1:0]         head_id;
    logic [SIZE_W-1:0]       head_size;
    logic                    dropped;
    logic [CREDIT_OUT_W-1:0] credits_left;
  } result_t;

  // decoded operation handed from the front end to the back end
  typedef struct packed {
    logic              do_pop;
    logic              do_push;
    logic [ID_W-1:0]   msg_id;
    logic [SIZE_W-1:0] msg_size;
    logic [COST_W-1:0] cost;
  } op_t;

endpackage

FILE: design/cmf_front.sv
`timescale 1ns / 1ps
// front end: accepts items, decodes the command and works out the credit cost
// depends on cmf_pkg

module cmf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [cmf_pkg::FLIT_W-1:0] flit_width,
  input  logic                       push,
  output logic                       full,
  input  cmf_pkg::item_t             item,
  output cmf_pkg::op_t               op,
  output logic                       op_push,
  input  logic                       op_full
);
  import cmf_pkg::*;

  localparam int DIV_CYCLES = SIZE_W / DIV_STEPS;
  localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUT} state_t;

  state_t              state;
  op_t                 op_reg;
  logic [FLIT_W-1:0]   divisor;
  logic [FLIT_W-1:0]   rem;
  logic [SIZE_W-1:0]   num;
  logic [STEP_W-1:0]   step;

  logic [FLIT_W-1:0]   rem_next;
  logic [SIZE_W-1:0]   num_next;
  logic [FLIT_W:0]     trial;
  logic                accept;
  logic                is_push;
  logic                is_pop;

  // radix-16 restoring division, four quotient bits per cycle
  always_comb begin
    trial    = '0;
    rem_next = rem;
    num_next = num;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial    = {rem_next, num_next[SIZE_W-1]};
      num_next = {num_next[SIZE_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial       = trial - {1'b0, divisor};
        num_next[0] = 1'b1;
      end
      rem_next = trial[FLIT_W-1:0];
    end
  end

  assign is_push = item.cmd inside {CMD_PUSH, CMD_POP_PUSH};
  assign is_pop  = item.cmd inside {CMD_POP, CMD_POP_PUSH};
  assign accept  = push && (state == F_IDLE);
  assign full    = (state != F_IDLE);
  assign op      = op_reg;
  assign op_push = (state == F_PUT) && !op_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            op_reg.do_pop   <= is_pop;
            op_reg.do_push  <= is_push;
            op_reg.msg_id   <= item.msg_id;
            op_reg.msg_size <= item.msg_size;
            op_reg.cost     <= '0;
            divisor         <= (flit_width == '0) ? FLIT_W'(1) : flit_width;
            rem             <= '0;
            num             <= item.msg_size;
            step            <= '0;
            state           <= is_push ? F_DIV : F_PUT;
          end
        end
        F_DIV: begin
          rem  <= rem_next;
          num  <= num_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_CYCLES - 1)) begin
            // round up: a partial flit still costs a credit
            op_reg.cost <= COST_W'(num_next) + COST_W'(rem_next != '0);
            state       <= F_PUT;
          end
        end
        F_PUT: begin
          if (!op_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/cmf_opq.sv
`timescale 1ns / 1ps
// short queue of decoded operations between the front and back ends
// depends on cmf_pkg

module cmf_opq (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  cmf_pkg::op_t wr_op,
  output logic         full,
  input  logic         rd,
  output cmf_pkg::op_t rd_op,
  output logic         empty
);
  import cmf_pkg::*;

  localparam int PTR_W = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

  op_t              entries [OPQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(OPQ_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

endmodule

FILE: design/cmf_back.sv
`timescale 1ns / 1ps
// back end: slot memory, credit pool and the result register
// depends on cmf_pkg

module cmf_back #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cmf_pkg::op_t     op,
  input  logic             op_empty,
  output logic             op_pop,
  output logic             empty,
  input  logic             pop,
  output cmf_pkg::result_t result
);
  import cmf_pkg::*;

  localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_DONE} state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  cost;
  } slot_t;

  slot_t            slots [BUFFER_DEPTH];
  slot_t            rd_data;

  state_t           state;
  op_t              cur;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] credit;
  logic             drop;
  logic             out_valid;
  result_t          out_result;

  logic             pop_ok;
  logic             push_ok;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [CNT_W-1:0] count_pop;
  logic [CNT_W-1:0] credit_pop;

  assign op_pop = (state == S_IDLE) && !op_empty && !out_valid;
  assign empty  = !out_valid;
  assign result = out_result;

  // pop first, then push against what the pop left
  always_comb begin
    pop_ok     = cur.do_pop && (count != '0);
    head_next  = head;
    count_pop  = count;
    credit_pop = credit;
    if (pop_ok) begin
      head_next  = (head == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : head + PTR_W'(1);
      count_pop  = count - CNT_W'(1);
      credit_pop = credit + rd_data.cost;
    end
    push_ok   = cur.do_push && (count_pop < CNT_W'(BUFFER_DEPTH)) &&
                (cur.cost <= COST_W'(credit_pop));
    tail_next = (tail == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
  end

  always_ff @(posedge clk) begin
    rd_data <= slots[head];
    if ((state == S_EXEC) && push_ok) begin
      slots[tail] <= '{id: cur.msg_id, size: cur.msg_size, cost: CNT_W'(cur.cost)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      credit    <= CNT_W'(BUFFER_DEPTH);
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (op_pop) begin
            cur   <= op;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          head   <= head_next;
          count  <= count_pop + CNT_W'(push_ok);
          credit <= credit_pop - (push_ok ? CNT_W'(cur.cost) : '0);
          drop   <= cur.do_push && !push_ok;
          if (push_ok) begin
            tail <= tail_next;
          end
          state <= S_READ;
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          out_valid               <= 1'b1;
          out_result.head_valid   <= (count != '0);
          out_result.head_id      <= (count != '0) ? rd_data.id : '0;
          out_result.head_size    <= (count != '0) ? rd_data.size : '0;
          out_result.dropped      <= drop;
          out_result.credits_left <= CREDIT_OUT_W'(credit);
          state                   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(BUFFER_DEPTH))
    else $error("message count above buffer depth");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CNT_W'(BUFFER_DEPTH))
    else $error("credit pool above buffer depth");

  a_empty_full_pool: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (credit == CNT_W'(BUFFER_DEPTH)))
    else $error("credits missing while queue is empty");

endmodule

FILE: design/credit_counted_message_fifo.sv
`timescale 1ns / 1ps
// top level of the credit counted message fifo (router input buffer)
// depends on cmf_pkg, cmf_front, cmf_opq, cmf_back

// A router input buffer that queues messages in arrival order against a pool
// of BUFFER_DEPTH credits; a message costs ceil(msg_size / flit_width) credits
// and is dropped (result dropped = 1) when credits or slots run short. Each
// item (idle, push, pop, or pop then push) gives exactly one result showing the
// head message and the credits left after it. A push item holds the front end
// through the transfer, the flit-count divider, which resolves four quotient
// bits per cycle over a 16-bit size, and the hand-off into the operation queue,
// which waits while that queue is full. Other items pass the front end with
// only the transfer and the hand-off. The back end takes every item through
// operation fetch, execute, head re-read through the registered read port of
// the slot memory, result load, and the result transfer that frees the result
// register; it fetches no new operation until that transfer. Front and back
// run on their own through a two-entry operation queue, and a finished result
// waits in its own register, so new items keep coming in while a result is not
// yet taken, until the operation queue and the front end fill up.
// flit_width is to be written through the cfg channel only while the block is
// idle, which the block itself does not enforce; zero is treated as one.

module credit_counted_message_fifo #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  cmf_pkg::item_t             item,
  output logic                       empty,
  input  logic                       pop,
  output cmf_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cmf_pkg::FLIT_W-1:0] cfg_data
);
  import cmf_pkg::*;

  logic [FLIT_W-1:0] flit_width;

  // decoded operations between the two halves
  op_t  fe_op;
  logic fe_op_push;
  logic q_full;
  op_t  q_op;
  logic q_empty;
  logic be_op_pop;

  // config register: one transfer per valid cycle, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flit_width <= FLIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      flit_width <= cfg_data;
    end
  end

  // front end: item transfer, command decode, credit cost
  cmf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .flit_width (flit_width),
    .push       (push),
    .full       (full),
    .item       (item),
    .op         (fe_op),
    .op_push    (fe_op_push),
    .op_full    (q_full)
  );

  // decoupling queue
  cmf_opq u_opq (
    .clk   (clk),
    .rst   (rst),
    .wr    (fe_op_push),
    .wr_op (fe_op),
    .full  (q_full),
    .rd    (be_op_pop),
    .rd_op (q_op),
    .empty (q_empty)
  );

  // back end: slot memory, pointers, credit pool, result register
  cmf_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (q_op),
    .op_empty (q_empty),
    .op_pop   (be_op_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
